// ===== rtl/gdkr_pkg.sv =====
// Shared types, constants and key mapping for the gesture d-pad key repeater.
package gdkr_pkg;

  // Fixed behavior constants
  localparam logic [7:0]  GRACE_FRAMES   = 8'd2;
  localparam logic [31:0] REPEAT_HOLD_MS = 32'd300;
  localparam logic [15:0] CMD_REPEAT_MS  = 16'd800;
  localparam logic        CONFIRM_ON     = 1'b1;
  localparam logic        BACK_ON        = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_GATE_ENTER  = 3'd0;
  localparam logic [2:0] REG_GATE_EXIT   = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [2:0] REG_CMD_DWELL   = 3'd3;
  localparam logic [2:0] REG_BACK_DWELL  = 3'd4;
  localparam logic [2:0] REG_REP_FIRST   = 3'd5;
  localparam logic [2:0] REG_REP_ACCEL   = 3'd6;
  localparam logic [2:0] REG_REP_MIN     = 3'd7;

  // Wedge codes
  localparam logic [2:0] WEDGE_NONE  = 3'd0;
  localparam logic [2:0] WEDGE_RIGHT = 3'd1;
  localparam logic [2:0] WEDGE_LEFT  = 3'd2;
  localparam logic [2:0] WEDGE_UP    = 3'd3;
  localparam logic [2:0] WEDGE_DOWN  = 3'd4;

  // Key codes
  localparam logic [2:0] KEY_NONE    = 3'd0;
  localparam logic [2:0] KEY_DOWN    = 3'd4;
  localparam logic [2:0] KEY_CONFIRM = 3'd5;
  localparam logic [2:0] KEY_BACK    = 3'd6;

  // Repeat status codes
  localparam logic [1:0] STAT_IDLE      = 2'd0;
  localparam logic [1:0] STAT_FIRED     = 2'd1;
  localparam logic [1:0] STAT_REPEATING = 2'd2;

  typedef struct packed {
    logic [11:0] gate_enter_radius;
    logic [11:0] gate_exit_radius;
    logic [7:0]  entry_debounce_frames;
    logic [15:0] cmd_dwell_ms;
    logic [15:0] back_dwell_ms;
    logic [15:0] repeat_first_ms;
    logic [15:0] repeat_accel_ms;
    logic [15:0] repeat_min_ms;
  } cfg_t;

  // occ_code: bit 3 is the command bit, bits 2:0 the wedge
  typedef struct packed {
    logic [3:0]  occ_code;
    logic [15:0] occ_frames;
    logic [7:0]  gap_count;
    logic        has_fired;
    logic        suppressed;
    logic        gate_on;
    logic [31:0] occ_since;
    logic [31:0] fired_at;
    logic [31:0] next_rep_at;
    logic [15:0] rep_count;
  } st_t;

  function automatic logic [2:0] key_for(input logic [2:0] w, input logic is_cmd);
    logic [2:0] k;
    if (is_cmd) begin
      if (w == WEDGE_RIGHT || w == WEDGE_UP) k = CONFIRM_ON ? KEY_CONFIRM : KEY_NONE;
      else k = BACK_ON ? KEY_BACK : KEY_NONE;
    end else begin
      k = (w == WEDGE_RIGHT || w == WEDGE_LEFT || w == WEDGE_UP) ? w : KEY_DOWN;
    end
    return k;
  endfunction

  function automatic logic [1:0] status_of(input st_t s);
    logic [1:0] r;
    if (s.rep_count != 16'd0) r = STAT_REPEATING;
    else if (s.has_fired) r = STAT_FIRED;
    else r = STAT_IDLE;
    return r;
  endfunction

endpackage

// ===== rtl/gdkr_step.sv =====
// Next-state and result logic for one frame of the key repeater.
module gdkr_step (
  input  gdkr_pkg::st_t  st_cur,
  input  gdkr_pkg::cfg_t cfg,
  input  logic [31:0]    time_ms,
  input  logic           hand_valid,
  input  logic           hand_parked,
  input  logic [2:0]     wedge,
  input  logic [11:0]    other_hand_dist,
  input  logic           restart,
  output gdkr_pkg::st_t  st_nxt,
  output logic [2:0]     key,
  output logic           cmd_mode,
  output logic [1:0]     repeat_status
);

  gdkr_pkg::st_t s;
  logic [2:0]  wedge_eff;
  logic [3:0]  occ;
  logic        gate;
  logic        clear_now;
  logic        same;
  logic [2:0]  w;
  logic        is_cmd;
  logic        is_back;
  logic        ready;
  logic [15:0] dwell;
  logic [31:0] since_dt;
  logic [31:0] fired_dt;
  logic [31:0] rep_dt;
  logic [15:0] mult_cnt;
  logic [31:0] prod;
  logic [32:0] diff;
  logic [15:0] iv;
  logic [15:0] rep_cnt_inc;

  // Shrinking interval: first - (count - 1) * accel, floored at the minimum.
  // Operands come from the held count, so (count_new - 1) is the old count.
  assign mult_cnt    = (st_cur.rep_count == 16'hFFFF) ? 16'hFFFE : st_cur.rep_count;
  assign prod        = mult_cnt * cfg.repeat_accel_ms;
  assign diff        = {17'd0, cfg.repeat_first_ms} - {1'b0, prod};
  assign iv          = (diff[32] || (diff[15:0] < cfg.repeat_min_ms)) ?
                       cfg.repeat_min_ms : diff[15:0];
  assign rep_cnt_inc = (st_cur.rep_count == 16'hFFFF) ? 16'hFFFF : st_cur.rep_count + 16'd1;

  always_comb begin
    s             = restart ? '0 : st_cur;
    key           = gdkr_pkg::KEY_NONE;
    cmd_mode      = 1'b0;
    repeat_status = gdkr_pkg::STAT_IDLE;
    wedge_eff     = (wedge > gdkr_pkg::WEDGE_DOWN) ? gdkr_pkg::WEDGE_NONE : wedge;
    gate          = s.gate_on ? (other_hand_dist < cfg.gate_exit_radius)
                              : (other_hand_dist < cfg.gate_enter_radius);
    occ           = 4'd0;
    clear_now     = 1'b0;
    same          = 1'b0;
    w             = 3'd0;
    is_cmd        = 1'b0;
    is_back       = 1'b0;
    ready         = 1'b0;
    dwell         = 16'd0;
    since_dt      = 32'd0;
    fired_dt      = 32'd0;
    rep_dt        = 32'd0;

    if (!hand_valid) begin
      // hold state
      cmd_mode      = s.gate_on;
      repeat_status = gdkr_pkg::status_of(s);
    end else if (hand_parked) begin
      s = '0;
    end else begin
      s.gate_on = gate;
      occ = (wedge_eff != gdkr_pkg::WEDGE_NONE) ? {gate, wedge_eff} : 4'd0;
      if (occ == 4'd0) begin
        if (s.gap_count != 8'hFF) s.gap_count = s.gap_count + 8'd1;
        if (s.occ_code != 4'd0 && s.gap_count <= gdkr_pkg::GRACE_FRAMES) occ = s.occ_code;
        else clear_now = 1'b1;
      end else begin
        s.gap_count = 8'd0;
      end

      if (clear_now) begin
        s = '0;
      end else begin
        if (occ != s.occ_code) begin
          same         = (occ[2:0] == s.occ_code[2:0]) && (s.occ_code[2:0] != 3'd0);
          s.occ_code   = occ;
          s.occ_frames = 16'd1;
          s.rep_count  = 16'd0;
          s.occ_since  = time_ms;
          s.has_fired  = same;
          s.suppressed = same;
        end else if (s.occ_frames != 16'hFFFF) begin
          s.occ_frames = s.occ_frames + 16'd1;
        end

        w        = s.occ_code[2:0];
        is_cmd   = s.occ_code[3];
        is_back  = is_cmd && (w == gdkr_pkg::WEDGE_LEFT || w == gdkr_pkg::WEDGE_DOWN);
        cmd_mode = s.gate_on;

        if (!s.suppressed) begin
          if (!s.has_fired) begin
            dwell    = is_back ? cfg.back_dwell_ms : cfg.cmd_dwell_ms;
            since_dt = time_ms - s.occ_since;
            ready    = is_cmd ? (since_dt >= {16'd0, dwell})
                              : (s.occ_frames >= {8'd0, cfg.entry_debounce_frames});
            if (ready) begin
              key           = gdkr_pkg::key_for(w, is_cmd);
              s.has_fired   = 1'b1;
              s.fired_at    = time_ms;
              s.next_rep_at = time_ms + {16'd0, is_cmd ? gdkr_pkg::CMD_REPEAT_MS
                                                       : cfg.repeat_first_ms};
            end
          end else begin
            fired_dt = time_ms - s.fired_at;
            rep_dt   = time_ms - s.next_rep_at;
            if (fired_dt >= gdkr_pkg::REPEAT_HOLD_MS && !rep_dt[31]) begin
              key           = gdkr_pkg::key_for(w, is_cmd);
              s.rep_count   = rep_cnt_inc;
              s.next_rep_at = time_ms + {16'd0, is_cmd ? gdkr_pkg::CMD_REPEAT_MS : iv};
            end
          end
          repeat_status = gdkr_pkg::status_of(s);
        end
      end
    end
    st_nxt = s;
  end

endmodule

// ===== rtl/gesture_dpad_key_repeater_unit.sv =====
// Top level of the gesture d-pad key repeater: handshake, registers and state.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  in_      | input     | in_valid / in_stall  | time_ms, hand_valid, hand_parked, wedge,
//           |           |                      | other_hand_dist, restart
//  out_     | output    | out_valid / out_stall| key, cmd_mode, repeat_status
//  cfg      | APB       | psel/penable/pready  | 8 registers at byte address 4*i
//
// One transaction in gives one transaction out, through the input register and
// then the result register, once the output is free. While out_stall is low the
// rate is one frame per cycle, set by the combinational state update between the input
// and result registers (one 16x16 multiply, subtract, compare and 32-bit add).
// Reset (rst_n low, synchronous) clears all tracking state, loads the register
// defaults and empties both stages. When out_stall holds the result, in_stall
// rises as soon as the input register is full; the input register takes one
// more frame only if it was empty.
module gesture_dpad_key_repeater_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_time_ms,
  input  logic        in_hand_valid,
  input  logic        in_hand_parked,
  input  logic [2:0]  in_wedge,
  input  logic [11:0] in_other_hand_dist,
  input  logic        in_restart,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_key,
  output logic        out_cmd_mode,
  output logic [1:0]  out_repeat_status,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gdkr_pkg::cfg_t cfg_r;
  gdkr_pkg::st_t  st_r;
  gdkr_pkg::st_t  st_nxt;

  // input register
  logic        s1_valid_r;
  logic [31:0] s1_time_ms_r;
  logic        s1_hand_valid_r;
  logic        s1_hand_parked_r;
  logic [2:0]  s1_wedge_r;
  logic [11:0] s1_dist_r;
  logic        s1_restart_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_key_r;
  logic        out_cmd_mode_r;
  logic [1:0]  out_status_r;

  logic [2:0]  step_key;
  logic        step_cmd_mode;
  logic [1:0]  step_status;
  logic        advance;
  logic        s1_load;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  // ---------------------------------------------------------------------------
  // Configuration port: zero wait state, write on the access phase.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_enter_radius     <= 12'd128;
      cfg_r.gate_exit_radius      <= 12'd160;
      cfg_r.entry_debounce_frames <= 8'd3;
      cfg_r.cmd_dwell_ms          <= 16'd400;
      cfg_r.back_dwell_ms         <= 16'd600;
      cfg_r.repeat_first_ms       <= 16'd400;
      cfg_r.repeat_accel_ms       <= 16'd50;
      cfg_r.repeat_min_ms         <= 16'd100;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gdkr_pkg::REG_GATE_ENTER: cfg_r.gate_enter_radius     <= pwdata[11:0];
        gdkr_pkg::REG_GATE_EXIT:  cfg_r.gate_exit_radius      <= pwdata[11:0];
        gdkr_pkg::REG_DEBOUNCE:   cfg_r.entry_debounce_frames <= pwdata[7:0];
        gdkr_pkg::REG_CMD_DWELL:  cfg_r.cmd_dwell_ms          <= pwdata[15:0];
        gdkr_pkg::REG_BACK_DWELL: cfg_r.back_dwell_ms         <= pwdata[15:0];
        gdkr_pkg::REG_REP_FIRST:  cfg_r.repeat_first_ms       <= pwdata[15:0];
        gdkr_pkg::REG_REP_ACCEL:  cfg_r.repeat_accel_ms       <= pwdata[15:0];
        gdkr_pkg::REG_REP_MIN:    cfg_r.repeat_min_ms         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    unique case (reg_idx)
      gdkr_pkg::REG_GATE_ENTER: prdata = {20'd0, cfg_r.gate_enter_radius};
      gdkr_pkg::REG_GATE_EXIT:  prdata = {20'd0, cfg_r.gate_exit_radius};
      gdkr_pkg::REG_DEBOUNCE:   prdata = {24'd0, cfg_r.entry_debounce_frames};
      gdkr_pkg::REG_CMD_DWELL:  prdata = {16'd0, cfg_r.cmd_dwell_ms};
      gdkr_pkg::REG_BACK_DWELL: prdata = {16'd0, cfg_r.back_dwell_ms};
      gdkr_pkg::REG_REP_FIRST:  prdata = {16'd0, cfg_r.repeat_first_ms};
      gdkr_pkg::REG_REP_ACCEL:  prdata = {16'd0, cfg_r.repeat_accel_ms};
      gdkr_pkg::REG_REP_MIN:    prdata = {16'd0, cfg_r.repeat_min_ms};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: the result register advances whenever it is empty or being
  // taken; the input register refills whenever it is empty or advancing.
  // ---------------------------------------------------------------------------
  assign advance  = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || advance;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload only moves with an accepted transaction.
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_time_ms_r     <= in_time_ms;
      s1_hand_valid_r  <= in_hand_valid;
      s1_hand_parked_r <= in_hand_parked;
      s1_wedge_r       <= in_wedge;
      s1_dist_r        <= in_other_hand_dist;
      s1_restart_r     <= in_restart;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame processing: one full state update per accepted frame.
  // ---------------------------------------------------------------------------
  gdkr_step u_step (
    .st_cur          (st_r),
    .cfg             (cfg_r),
    .time_ms         (s1_time_ms_r),
    .hand_valid      (s1_hand_valid_r),
    .hand_parked     (s1_hand_parked_r),
    .wedge           (s1_wedge_r),
    .other_hand_dist (s1_dist_r),
    .restart         (s1_restart_r),
    .st_nxt          (st_nxt),
    .key             (step_key),
    .cmd_mode        (step_cmd_mode),
    .repeat_status   (step_status)
  );

  // Commit state only when the frame moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance && s1_valid_r) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_key_r      <= step_key;
      out_cmd_mode_r <= step_cmd_mode;
      out_status_r   <= step_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key           = out_key_r;
  assign out_cmd_mode      = out_cmd_mode_r;
  assign out_repeat_status = out_status_r;

endmodule

// ===== rtl/gdkr_checker.sv =====
// Port-level assertions for the gesture d-pad key repeater, bound to the top level.
module gdkr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_key,
  input logic        out_cmd_mode,
  input logic [1:0]  out_repeat_status
);

  // A key press always marks the repeater as fired or repeating.
  a_key_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key != gdkr_pkg::KEY_NONE |-> out_repeat_status != gdkr_pkg::STAT_IDLE)
    else $error("key issued with idle repeat status");

  // Status stays within its three codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_repeat_status == gdkr_pkg::STAT_IDLE ||
                  out_repeat_status == gdkr_pkg::STAT_FIRED ||
                  out_repeat_status == gdkr_pkg::STAT_REPEATING)
    else $error("repeat status out of range");

  // After reset no result is pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n ##1 !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A held result keeps its payload.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key) &&
                               $stable(out_cmd_mode) && $stable(out_repeat_status))
    else $error("stalled result changed");

  // With no result pending the input is never held off.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result side is empty");

endmodule

bind gesture_dpad_key_repeater_unit gdkr_checker u_gdkr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_key           (out_key),
  .out_cmd_mode      (out_cmd_mode),
  .out_repeat_status (out_repeat_status)
);

// ===== tb/tb_gesture_dpad_key_repeater_unit.sv =====
// Self-checking testbench for the gesture d-pad key repeater unit.
module tb_gesture_dpad_key_repeater_unit;
  import gdkr_pkg::*;

  // Wedge codes past DOWN are junk and must act as no wedge
  localparam logic [2:0] WEDGE_JUNK_MIN = 3'd5;
  localparam logic [2:0] WEDGE_JUNK_MAX = 3'd7;

  // One frame as it enters the block
  typedef struct packed {
    logic [31:0] time_ms;
    logic        hand_valid;
    logic        hand_parked;
    logic [2:0]  wedge;
    logic [11:0] other_dist;
    logic        restart;
  } frame_t;

  // One result as it leaves the block
  typedef struct packed {
    logic [2:0] key;
    logic       cmd_mode;
    logic [1:0] status;
  } keyout_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_time_ms = '0;
  logic        in_hand_valid = 1'b0;
  logic        in_hand_parked = 1'b0;
  logic [2:0]  in_wedge = WEDGE_NONE;
  logic [11:0] in_other_hand_dist = '0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_key;
  logic        out_cmd_mode;
  logic [1:0]  out_repeat_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gesture_dpad_key_repeater_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_time_ms         (in_time_ms),
    .in_hand_valid      (in_hand_valid),
    .in_hand_parked     (in_hand_parked),
    .in_wedge           (in_wedge),
    .in_other_hand_dist (in_other_hand_dist),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_key            (out_key),
    .out_cmd_mode       (out_cmd_mode),
    .out_repeat_status  (out_repeat_status),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copy plus the key-tracking state
  // ---------------------------------------------------------------------------
  cfg_t        regs;
  logic [3:0]  held_code;      // bit 3 command gate, bits 2:0 wedge
  logic [15:0] held_frames;
  logic [7:0]  empty_run;      // consecutive frames with no wedge
  logic        fired;
  logic        muted;          // mode flip: same wedge, other gate side
  logic        gate_state;
  logic [31:0] held_since;
  logic [31:0] fired_ms;
  logic [31:0] next_rep_ms;
  logic [15:0] rep_cnt;

  keyout_t     pending_keys[$];  // predicted results in transaction order
  keyout_t     want;

  int          mismatches = 0;
  int          results_seen = 0;
  int          frames_sent = 0;
  int          settings_loaded = 0;

  // Stimulus knobs
  logic [31:0] now_ms = 32'd1000;
  int          long_step = 2000;
  int          hold_max = 60;
  bit          idle_allowed = 1'b1;
  bit          idle_on = 1'b1;
  int          hold_request = 0;
  int          stall_left = 0;

  function automatic void clear_tracker();
    held_code = '0;
    held_frames = '0;
    empty_run = '0;
    fired = 1'b0;
    muted = 1'b0;
    gate_state = 1'b0;
    held_since = '0;
    fired_ms = '0;
    next_rep_ms = '0;
    rep_cnt = '0;
  endfunction

  // Register values the block comes out of reset with
  function automatic void load_defaults();
    regs.gate_enter_radius = 12'd128;
    regs.gate_exit_radius = 12'd160;
    regs.entry_debounce_frames = 8'd3;
    regs.cmd_dwell_ms = 16'd400;
    regs.back_dwell_ms = 16'd600;
    regs.repeat_first_ms = 16'd400;
    regs.repeat_accel_ms = 16'd50;
    regs.repeat_min_ms = 16'd100;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      REG_GATE_ENTER: regs.gate_enter_radius = value[11:0];
      REG_GATE_EXIT:  regs.gate_exit_radius = value[11:0];
      REG_DEBOUNCE:   regs.entry_debounce_frames = value[7:0];
      REG_CMD_DWELL:  regs.cmd_dwell_ms = value[15:0];
      REG_BACK_DWELL: regs.back_dwell_ms = value[15:0];
      REG_REP_FIRST:  regs.repeat_first_ms = value[15:0];
      REG_REP_ACCEL:  regs.repeat_accel_ms = value[15:0];
      REG_REP_MIN:    regs.repeat_min_ms = value[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [1:0] repeat_state();
    if (rep_cnt != 16'd0) return STAT_REPEATING;
    if (fired) return STAT_FIRED;
    return STAT_IDLE;
  endfunction

  // Key a held wedge produces: plain directions map straight through,
  // command wedges become confirm (right, up) or back (left, down)
  function automatic logic [2:0] key_code(input logic [2:0] w, input logic is_cmd);
    if (!is_cmd) return w;
    case (w)
      WEDGE_RIGHT, WEDGE_UP: return CONFIRM_ON ? KEY_CONFIRM : KEY_NONE;
      default:               return BACK_ON ? KEY_BACK : KEY_NONE;
    endcase
  endfunction

  // Advance the shadow state by one frame and return the result it gives
  function automatic keyout_t predict_key(input frame_t f);
    logic [3:0]  code;
    logic [2:0]  w;
    logic        is_cmd;
    logic        same;
    logic        ready;
    logic [31:0] dwell;
    logic [31:0] elapsed;
    logic [31:0] lag;
    longint      gap_ms;
    longint      floor_ms;
    longint      accel_ms;
    longint      count;
    keyout_t     r;
    r = '0;
    if (f.restart) clear_tracker();
    // Lost hand: hold everything, report the held gate and status
    if (!f.hand_valid) begin
      r.cmd_mode = gate_state;
      r.status = repeat_state();
      return r;
    end
    if (f.hand_parked) begin
      clear_tracker();
      return r;
    end
    // Sticky gate: enter radius to turn on, exit radius to stay on
    gate_state = gate_state ? (f.other_dist < regs.gate_exit_radius)
                            : (f.other_dist < regs.gate_enter_radius);
    w = (f.wedge > WEDGE_DOWN) ? WEDGE_NONE : f.wedge;
    code = (w == WEDGE_NONE) ? 4'd0 : {gate_state, w};
    if (code == 4'd0) begin
      if (empty_run != 8'hFF) empty_run++;
      if (held_code != 4'd0 && empty_run <= GRACE_FRAMES) begin
        code = held_code;
      end else begin
        clear_tracker();
        return r;
      end
    end else begin
      empty_run = '0;
    end
    if (code != held_code) begin
      same = (code[2:0] == held_code[2:0]) && (held_code[2:0] != WEDGE_NONE);
      held_code = code;
      held_frames = 16'd1;
      rep_cnt = '0;
      held_since = f.time_ms;
      fired = same;
      muted = same;
    end else if (held_frames != 16'hFFFF) begin
      held_frames++;
    end
    w = held_code[2:0];
    is_cmd = held_code[3];
    r.cmd_mode = gate_state;
    if (muted) return r;
    if (!fired) begin
      if (is_cmd) begin
        dwell = (w == WEDGE_LEFT || w == WEDGE_DOWN) ? {16'd0, regs.back_dwell_ms}
                                                     : {16'd0, regs.cmd_dwell_ms};
        elapsed = f.time_ms - held_since;
        ready = elapsed >= dwell;
      end else begin
        ready = held_frames >= {8'd0, regs.entry_debounce_frames};
      end
      if (ready) begin
        r.key = key_code(w, is_cmd);
        fired = 1'b1;
        fired_ms = f.time_ms;
        next_rep_ms = f.time_ms + (is_cmd ? {16'd0, CMD_REPEAT_MS}
                                          : {16'd0, regs.repeat_first_ms});
      end
    end else begin
      elapsed = f.time_ms - fired_ms;
      lag = f.time_ms - next_rep_ms;
      if (elapsed >= REPEAT_HOLD_MS && !lag[31]) begin
        r.key = key_code(w, is_cmd);
        if (rep_cnt != 16'hFFFF) rep_cnt++;
        if (is_cmd) begin
          gap_ms = CMD_REPEAT_MS;
        end else begin
          // Shrink the interval per repeat, never below the floor
          gap_ms = regs.repeat_first_ms;
          accel_ms = regs.repeat_accel_ms;
          count = rep_cnt;
          floor_ms = regs.repeat_min_ms;
          gap_ms = gap_ms - (count - 1) * accel_ms;
          if (gap_ms < floor_ms) gap_ms = floor_ms;
        end
        next_rep_ms = f.time_ms + 32'(gap_ms);
      end
    end
    r.status = repeat_state();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected result: key %0d cmd_mode %0d status %0d", $time,
                 out_key, out_cmd_mode, out_repeat_status);
        mismatches++;
      end else begin
        want = pending_keys.pop_front();
        if (out_key !== want.key) begin
          $display("%0t: key mismatch: expected %0d, actual %0d", $time, want.key, out_key);
          mismatches++;
        end
        if (out_cmd_mode !== want.cmd_mode) begin
          $display("%0t: cmd_mode mismatch: expected %0d, actual %0d", $time,
                   want.cmd_mode, out_cmd_mode);
          mismatches++;
        end
        if (out_repeat_status !== want.status) begin
          $display("%0t: repeat_status mismatch: expected %0d, actual %0d", $time,
                   want.status, out_repeat_status);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame side
  // ---------------------------------------------------------------------------

  // Offer one frame, hold it until accepted, then record its prediction.
  // Valid stays high afterwards; the next call or wait_idle decides.
  task automatic send_frame(input frame_t f);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_time_ms <= f.time_ms;
    in_hand_valid <= f.hand_valid;
    in_hand_parked <= f.hand_parked;
    in_wedge <= f.wedge;
    in_other_hand_dist <= f.other_dist;
    in_restart <= f.restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_keys.push_back(predict_key(f));
    if (f.hand_valid) frames_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, register taken at the access edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    apply_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic load_registers(input logic [11:0] enter, input logic [11:0] leave,
                                input logic [7:0] debounce, input logic [15:0] cmd_dwell,
                                input logic [15:0] back_dwell, input logic [15:0] first,
                                input logic [15:0] accel, input logic [15:0] floor_ms);
    write_reg(REG_GATE_ENTER, {20'd0, enter});
    write_reg(REG_GATE_EXIT, {20'd0, leave});
    write_reg(REG_DEBOUNCE, {24'd0, debounce});
    write_reg(REG_CMD_DWELL, {16'd0, cmd_dwell});
    write_reg(REG_BACK_DWELL, {16'd0, back_dwell});
    write_reg(REG_REP_FIRST, {16'd0, first});
    write_reg(REG_REP_ACCEL, {16'd0, accel});
    write_reg(REG_REP_MIN, {16'd0, floor_ms});
    settings_loaded++;
  endtask

  // Plain, hand-present frame, advance the timestamp by adv
  function automatic frame_t frame_at(input logic [31:0] adv, input logic [2:0] w,
                                      input logic [11:0] d);
    frame_t f;
    now_ms = now_ms + adv;
    f = '0;
    f.time_ms = now_ms;
    f.hand_valid = 1'b1;
    f.wedge = w;
    f.other_dist = d;
    return f;
  endfunction

  // Mostly camera-rate steps; sometimes zero or long enough to pass dwells
  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, long_step);
      1: return 32'd0;
      default: return $urandom_range(10, 60);
    endcase
  endfunction

  // Distances clustered around the gate radii so the hysteresis gets hit
  function automatic logic [11:0] pick_dist();
    logic [11:0] d;
    case ($urandom_range(0, 5))
      0: d = 12'($urandom_range(0, regs.gate_enter_radius));
      1: d = regs.gate_enter_radius - 12'($urandom_range(0, 1));
      2: d = regs.gate_exit_radius - 12'($urandom_range(0, 1));
      3: d = 12'($urandom_range(0, 4095));
      default: d = 12'hFFF;
    endcase
    return d;
  endfunction

  // One held gesture: a wedge kept for a while with dropouts, short gaps
  // and gate changes mixed in, then released
  task automatic play_gesture();
    logic [2:0]  w;
    logic [11:0] d;
    int          hold;
    frame_t      f;
    w = 3'($urandom_range(WEDGE_RIGHT, WEDGE_DOWN));
    d = pick_dist();
    hold = ($urandom_range(0, 3) == 0) ? $urandom_range(15, hold_max) : $urandom_range(1, 15);
    for (int n = 0; n < hold; n++) begin
      f = frame_at(pick_step(), w, d);
      case ($urandom_range(0, 19))
        0: f.hand_valid = 1'b0;
        1: f.wedge = WEDGE_NONE;
        2: d = pick_dist();
        3: f.wedge = 3'($urandom_range(WEDGE_JUNK_MIN, WEDGE_JUNK_MAX));
        default: ;
      endcase
      send_frame(f);
    end
    repeat ($urandom_range(0, 4)) begin
      f = frame_at(pick_step(), WEDGE_NONE, pick_dist());
      if ($urandom_range(0, 3) == 0) begin
        f.wedge = 3'($urandom_range(WEDGE_JUNK_MIN, WEDGE_JUNK_MAX));
      end
      send_frame(f);
    end
  endtask

  // Fully random frame, including jumps of the timestamp anywhere
  task automatic send_noise();
    frame_t f;
    f = frame_at(pick_step(), 3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)));
    if ($urandom_range(0, 3) == 0) begin
      now_ms = $urandom;
      f.time_ms = now_ms;
    end
    f.hand_valid = $urandom_range(0, 4) != 0;
    f.hand_parked = $urandom_range(0, 3) == 0;
    f.restart = $urandom_range(0, 3) == 0;
    send_frame(f);
  endtask

  task automatic run_traffic(input int budget);
    int target;
    target = frames_sent + budget;
    while (frames_sent < target) begin
      idle_on = idle_allowed && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) send_noise();
      else play_gesture();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked frames under the reset register values
  task automatic test_directed_cases();
    frame_t f;
    // Plain right: fire on the third frame, repeat once the hold has passed
    repeat (3) send_frame(frame_at(33, WEDGE_RIGHT, 12'hFFF));
    send_frame(frame_at(450, WEDGE_RIGHT, 12'hFFF));
    // One empty frame stays within grace, the wedge carries on
    send_frame(frame_at(33, WEDGE_NONE, 12'hFFF));
    send_frame(frame_at(33, WEDGE_RIGHT, 12'hFFF));
    // Junk wedge counts as empty; the third one runs out of grace
    repeat (3) send_frame(frame_at(33, WEDGE_JUNK_MAX, 12'hFFF));
    send_frame(frame_at(33, WEDGE_NONE, 12'hFFF));
    // Plain down fires, hand loss holds, parking clears
    repeat (3) send_frame(frame_at(33, WEDGE_DOWN, 12'hFFF));
    f = frame_at(33, WEDGE_DOWN, 12'hFFF);
    f.hand_valid = 1'b0;
    send_frame(f);
    f = frame_at(33, WEDGE_DOWN, 12'hFFF);
    f.hand_parked = 1'b1;
    send_frame(f);
    // Command confirm: near hand opens the gate, a distance between the
    // radii keeps it open, the dwell passes
    send_frame(frame_at(33, WEDGE_UP, 12'h000));
    send_frame(frame_at(450, WEDGE_UP, 12'd150));
    // Gate drops with the same wedge: mode flip, suppressed
    send_frame(frame_at(33, WEDGE_UP, 12'hFFF));
    // Command back, then its fixed-interval repeat
    send_frame(frame_at(33, WEDGE_LEFT, 12'd100));
    send_frame(frame_at(650, WEDGE_LEFT, 12'd100));
    send_frame(frame_at(850, WEDGE_LEFT, 12'd100));
    // Restart mid-hold, then carry a plain left across the timestamp wrap
    f = frame_at(33, WEDGE_LEFT, 12'hFFF);
    f.restart = 1'b1;
    send_frame(f);
    now_ms = 32'hFFFF_FFDE;
    send_frame(frame_at(33, WEDGE_LEFT, 12'hFFF));
    send_frame(frame_at(1, WEDGE_LEFT, 12'hFFF));
    send_frame(frame_at(400, WEDGE_LEFT, 12'hFFF));
  endtask

  task automatic test_default_traffic();
    run_traffic(300);
  endtask

  // Hold the result side long enough to back up the input, then pause
  // the sender until everything has drained
  task automatic test_backpressure();
    hold_request = 150;
    run_traffic(40);
    wait_idle();
    run_traffic(40);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    load_registers('0, '0, '0, '0, '0, '0, '0, '0);
    run_traffic(150);
    wait_idle();
    long_step = 70000;
    hold_max = 280;
    load_registers('1, '1, '1, '1, '1, '1, '1, '1);
    run_traffic(150);
    hold_max = 60;
  endtask

  task automatic test_random_registers();
    for (int round = 0; round < 3; round++) begin
      wait_idle();
      long_step = 3000;
      load_registers(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     8'($urandom_range(0, 8)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1000)),
                     16'($urandom_range(0, 300)), 16'($urandom_range(0, 400)));
      run_traffic(130);
    end
  endtask

  // Back to the reset values, with both sides running flat out
  task automatic test_steady_stream();
    wait_idle();
    idle_allowed = 1'b0;
    idle_on = 1'b0;
    long_step = 2000;
    load_registers(12'd128, 12'd160, 8'd3, 16'd400, 16'd600, 16'd400, 16'd50, 16'd100);
    run_traffic(180);
  endtask

  initial begin
    load_defaults();
    clear_tracker();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_default_traffic();
    test_backpressure();
    test_register_extremes();
    test_random_registers();
    test_steady_stream();
    wait_idle();
    $display("Checked %0d results from %0d hand frames over %0d register settings,",
             results_seen, frames_sent, settings_loaded);
    $display("including stall bursts, a long output hold-off and timestamp wrap.");
    if (mismatches == 0) begin
      $display("gesture_dpad_key_repeater_unit test passed");
    end else begin
      $display("gesture_dpad_key_repeater_unit test failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #5000000;
    $display("gesture_dpad_key_repeater_unit test failed");
    $finish;
  end

endmodule

// ===== gesture_dpad_key_repeater_unit.f =====
rtl/gdkr_pkg.sv
rtl/gdkr_step.sv
rtl/gesture_dpad_key_repeater_unit.sv
rtl/gdkr_checker.sv
tb/tb_gesture_dpad_key_repeater_unit.sv
